// File: rtl/dlv_pkg.sv
// shared types, constants and class-pair table for the decimal literal validator
// no dependencies
`timescale 1ns / 1ps

package dlv_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_EXP   = 8'h65;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CLS_DIGIT = 3'd0,
        CLS_SIGN  = 3'd1,
        CLS_DOT   = 3'd2,
        CLS_EXP   = 3'd3,
        CLS_END   = 3'd4,
        CLS_BAD   = 3'd5,
        CLS_SPACE = 3'd6
    } cls_t;

    typedef struct packed {
        logic term;
        cls_t cls;
    } item_t;

    // bit n of a row is set when class n may follow the row's class
    localparam logic [4:0] PAIR_OK [5] = '{
        5'b11101,
        5'b00101,
        5'b11001,
        5'b00011,
        5'b00111
    };

    function automatic logic pair_allowed(logic [2:0] prev, logic [2:0] cur);
        logic ok;
        if (prev > 3'(CLS_END) || cur > 3'(CLS_END)) begin
            ok = 1'b0;
        end else begin
            ok = PAIR_OK[prev][cur];
        end
        return ok;
    endfunction

endpackage

// File: rtl/decimal_literal_validator_core.sv
// Decimal literal validator: takes a string one byte per transfer (s_tlast marks the
// terminator transfer, whose byte is ignored) and answers on m_tdata[0] whether the string
// is a valid decimal literal. One byte is accepted every cycle while s_tready is high; a
// byte is classified on entry, queued in a FIFO_DEPTH-entry queue and consumed by the
// grammar state one per cycle unless a terminator waits at the head behind a stalled
// result register, which holds the verdict and drives m_tvalid. Only the terminator
// produces a result; s_tready drops only when the queue fills behind that register.
// depends on dlv_pkg, dlv_front, dlv_fifo, dlv_back
`timescale 1ns / 1ps

module decimal_literal_validator_core #(
    parameter int FIFO_DEPTH = dlv_pkg::FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] char_code
    input  logic       s_tlast,     // terminator
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // [0] is_valid_number, [7:1] zero
);

    logic           q_full, q_push, q_valid, q_pop;
    dlv_pkg::item_t push_item, head_item;

    dlv_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    dlv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    dlv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/dlv_front.sv
// front end: input handshake and byte classification into queue items
// depends on dlv_pkg
`timescale 1ns / 1ps

module dlv_front (
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           q_full,
    output logic           q_push,
    output dlv_pkg::item_t q_item
);

    function automatic dlv_pkg::cls_t classify(logic [7:0] c);
        dlv_pkg::cls_t cls;
        priority if (c == dlv_pkg::CHAR_SPACE) begin
            cls = dlv_pkg::CLS_SPACE;
        end else if (c == dlv_pkg::CHAR_EXP) begin
            cls = dlv_pkg::CLS_EXP;
        end else if (c == dlv_pkg::CHAR_PLUS || c == dlv_pkg::CHAR_MINUS) begin
            cls = dlv_pkg::CLS_SIGN;
        end else if (c == dlv_pkg::CHAR_DOT) begin
            cls = dlv_pkg::CLS_DOT;
        end else if (c >= dlv_pkg::CHAR_ZERO && c <= dlv_pkg::CHAR_NINE) begin
            cls = dlv_pkg::CLS_DIGIT;
        end else begin
            cls = dlv_pkg::CLS_BAD;
        end
        return cls;
    endfunction

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;
    assign q_item.term = s_tlast;
    assign q_item.cls  = s_tlast ? dlv_pkg::CLS_END : classify(s_tdata);

endmodule

// File: rtl/dlv_fifo.sv
// short queue of classified items between front and back end
// depends on dlv_pkg
`timescale 1ns / 1ps

module dlv_fifo #(
    parameter int DEPTH = dlv_pkg::FIFO_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dlv_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output dlv_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dlv_pkg::item_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/dlv_back.sv
// back end: literal grammar state, verdict on terminator, output register
// depends on dlv_pkg
`timescale 1ns / 1ps

module dlv_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  dlv_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata      // [0] is_valid_number, [7:1] zero
);

    dlv_pkg::cls_t prev_class_reg, prev_class_next;
    logic          digit_seen_reg, digit_seen_next;
    logic [1:0]    sign_count_reg, sign_count_next;
    logic          dot_seen_reg, dot_seen_next;
    logic          exp_seen_reg, exp_seen_next;
    logic          dot_barred_reg, dot_barred_next;
    logic          rejected_reg, rejected_next;
    logic          started_reg, started_next;
    logic          trailing_reg, trailing_next;
    logic          out_valid_reg, out_valid_next;
    logic          result_reg, result_next;
    logic          out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && (!q_item.term || out_free);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, result_reg};

    always_comb begin
        prev_class_next = prev_class_reg;
        digit_seen_next = digit_seen_reg;
        sign_count_next = sign_count_reg;
        dot_seen_next   = dot_seen_reg;
        exp_seen_next   = exp_seen_reg;
        dot_barred_next = dot_barred_reg;
        rejected_next   = rejected_reg;
        started_next    = started_reg;
        trailing_next   = trailing_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        result_next     = result_reg;

        if (q_pop) begin
            if (q_item.term) begin
                out_valid_next  = 1'b1;
                result_next     = !rejected_reg && digit_seen_reg
                    && dlv_pkg::pair_allowed(prev_class_reg, dlv_pkg::CLS_END);
                prev_class_next = dlv_pkg::CLS_END;
                digit_seen_next = 1'b0;
                sign_count_next = 2'd0;
                dot_seen_next   = 1'b0;
                exp_seen_next   = 1'b0;
                dot_barred_next = 1'b0;
                rejected_next   = 1'b0;
                started_next    = 1'b0;
                trailing_next   = 1'b0;
            end else if (rejected_reg) begin
                rejected_next = 1'b1;
            end else if (q_item.cls == dlv_pkg::CLS_SPACE) begin
                if (started_reg) begin
                    trailing_next = 1'b1;
                end
            end else if (trailing_reg) begin
                rejected_next = 1'b1;
            end else begin
                started_next = 1'b1;
                if (q_item.cls == dlv_pkg::CLS_BAD
                    || !dlv_pkg::pair_allowed(prev_class_reg, q_item.cls)) begin
                    rejected_next = 1'b1;
                end else begin
                    prev_class_next = q_item.cls;
                    unique case (q_item.cls)
                        dlv_pkg::CLS_DIGIT: begin
                            digit_seen_next = 1'b1;
                        end
                        dlv_pkg::CLS_SIGN: begin
                            if (sign_count_reg >= 2'd2) begin
                                rejected_next = 1'b1;
                            end else begin
                                sign_count_next = sign_count_reg + 2'd1;
                            end
                        end
                        dlv_pkg::CLS_DOT: begin
                            if (dot_seen_reg || dot_barred_reg) begin
                                rejected_next = 1'b1;
                            end else begin
                                dot_seen_next = 1'b1;
                            end
                        end
                        dlv_pkg::CLS_EXP: begin
                            if (exp_seen_reg || !digit_seen_reg) begin
                                rejected_next = 1'b1;
                            end
                            exp_seen_next   = 1'b1;
                            dot_barred_next = 1'b1;
                        end
                        default: begin
                            rejected_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_class_reg <= dlv_pkg::CLS_END;
            digit_seen_reg <= 1'b0;
            sign_count_reg <= 2'd0;
            dot_seen_reg   <= 1'b0;
            exp_seen_reg   <= 1'b0;
            dot_barred_reg <= 1'b0;
            rejected_reg   <= 1'b0;
            started_reg    <= 1'b0;
            trailing_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prev_class_reg <= prev_class_next;
            digit_seen_reg <= digit_seen_next;
            sign_count_reg <= sign_count_next;
            dot_seen_reg   <= dot_seen_next;
            exp_seen_reg   <= exp_seen_next;
            dot_barred_reg <= dot_barred_next;
            rejected_reg   <= rejected_next;
            started_reg    <= started_next;
            trailing_reg   <= trailing_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

endmodule

// File: bench/decimal_literal_validator_core_tb.sv
// self-checking bench for decimal_literal_validator_core: streams byte strings with
// terminators, predicts each verdict in a local scanner and checks every result transfer
// depends on dlv_pkg and decimal_literal_validator_core
`timescale 1ns / 1ps

module decimal_literal_validator_core_tb;

    localparam int unsigned HALF_PERIOD      = 6;
    localparam int unsigned RESET_CYCLES     = 12;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES     = 10;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;    // terminator
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] is_valid_number, [7:1] zero

    // scanner state mirroring the block
    dlv_pkg::cls_t sc_prev;
    bit            sc_digit;
    bit [1:0]      sc_signs;
    bit            sc_dot;
    bit            sc_exp;
    bit            sc_dot_barred;
    bit            sc_rejected;
    bit            sc_started;
    bit            sc_trailing;

    bit          verdict_q [$];
    logic [7:0]  literal_buf [$];
    bit          no_gaps;
    bit          sink_hold_req;
    int unsigned mismatches;
    int unsigned sent_items;
    int unsigned strings_sent;
    int unsigned valid_seen;
    int unsigned invalid_seen;
    int unsigned input_stalls;
    int unsigned idle_cycles;

    decimal_literal_validator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic void scan_clear();
        sc_prev       = dlv_pkg::CLS_END;
        sc_digit      = 1'b0;
        sc_signs      = 2'd0;
        sc_dot        = 1'b0;
        sc_exp        = 1'b0;
        sc_dot_barred = 1'b0;
        sc_rejected   = 1'b0;
        sc_started    = 1'b0;
        sc_trailing   = 1'b0;
    endfunction

    function automatic dlv_pkg::cls_t char_class(input logic [7:0] code);
        dlv_pkg::cls_t cls;
        if (code == dlv_pkg::CHAR_EXP) begin
            cls = dlv_pkg::CLS_EXP;
        end else if (code == dlv_pkg::CHAR_PLUS || code == dlv_pkg::CHAR_MINUS) begin
            cls = dlv_pkg::CLS_SIGN;
        end else if (code == dlv_pkg::CHAR_DOT) begin
            cls = dlv_pkg::CLS_DOT;
        end else if (code >= dlv_pkg::CHAR_ZERO && code <= dlv_pkg::CHAR_NINE) begin
            cls = dlv_pkg::CLS_DIGIT;
        end else begin
            cls = dlv_pkg::CLS_BAD;
        end
        return cls;
    endfunction

    // bit n of the row is set when class n may follow prev
    function automatic bit class_follows(input dlv_pkg::cls_t prev,
                                         input dlv_pkg::cls_t cur);
        logic [4:0] row;
        case (prev)
            dlv_pkg::CLS_DIGIT: row = 5'b11101;
            dlv_pkg::CLS_SIGN:  row = 5'b00101;
            dlv_pkg::CLS_DOT:   row = 5'b11001;
            dlv_pkg::CLS_EXP:   row = 5'b00011;
            dlv_pkg::CLS_END:   row = 5'b00111;
            default:            row = 5'b00000;
        endcase
        return (cur > dlv_pkg::CLS_END) ? 1'b0 : row[cur];
    endfunction

    function automatic void scan_transfer(input logic [7:0] code, input logic last,
                                          output bit has_verdict, output bit verdict);
        dlv_pkg::cls_t cls;
        has_verdict = 1'b0;
        verdict     = 1'b0;
        if (last) begin
            has_verdict = 1'b1;
            verdict     = !sc_rejected && class_follows(sc_prev, dlv_pkg::CLS_END)
                && sc_digit;
            scan_clear();
        end else if (!sc_rejected) begin
            if (code == dlv_pkg::CHAR_SPACE) begin
                if (sc_started) sc_trailing = 1'b1;
            end else if (sc_trailing) begin
                sc_rejected = 1'b1;
            end else begin
                sc_started = 1'b1;
                cls = char_class(code);
                if (cls == dlv_pkg::CLS_BAD || !class_follows(sc_prev, cls)) begin
                    sc_rejected = 1'b1;
                end else begin
                    case (cls)
                        dlv_pkg::CLS_DIGIT: sc_digit = 1'b1;
                        dlv_pkg::CLS_SIGN: begin
                            if (sc_signs >= 2'd2) sc_rejected = 1'b1;
                            else sc_signs = sc_signs + 2'd1;
                        end
                        dlv_pkg::CLS_DOT: begin
                            if (sc_dot || sc_dot_barred) sc_rejected = 1'b1;
                            else sc_dot = 1'b1;
                        end
                        default: begin
                            if (sc_exp || !sc_digit) sc_rejected = 1'b1;
                            sc_exp        = 1'b1;
                            sc_dot_barred = 1'b1;
                        end
                    endcase
                    sc_prev = cls;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // transfer monitor: predicts on input transfers, checks result transfers, watchdog
    always @(posedge aclk) begin : transfer_monitor
        bit has_verdict;
        bit verdict;
        bit wanted;
        bit moved;
        if (!aresetn) begin
            scan_clear();
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (m_tvalid === 1'b1 && m_tready) begin
                moved = 1'b1;
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with nothing pending", m_tdata));
                end else begin
                    wanted = verdict_q.pop_front();
                    if (m_tdata[0] !== wanted)
                        report_mismatch($sformatf("is_valid_number %b, expected %b",
                                                  m_tdata[0], wanted));
                    if (m_tdata[7:1] !== 7'd0)
                        report_mismatch($sformatf("padding bits 0x%02h not zero", m_tdata[7:1]));
                end
                if (m_tdata[0] === 1'b1) valid_seen++;
                else invalid_seen++;
            end
            if (s_tvalid && s_tready === 1'b1) begin
                moved = 1'b1;
                scan_transfer(s_tdata, s_tlast, has_verdict, verdict);
                if (has_verdict) verdict_q.push_back(verdict);
            end else if (s_tvalid) begin
                input_stalls++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles, %0d results pending",
                         $realtime, idle_cycles, verdict_q.size());
                $display("decimal_literal_validator_core verification failed");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin : result_sink
        int unsigned r;
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
                r = $urandom_range(0, 99);
                if (!no_gaps && r < 30) begin
                    m_tready <= 1'b0;
                    repeat ((r < 3) ? $urandom_range(20, 60) : $urandom_range(1, 3))
                        @(posedge aclk);
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns at the edge of the transfer or after the gap
    task automatic send_byte(input logic [7:0] code, input logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sent_items++;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_literal();
        foreach (literal_buf[i]) send_byte(literal_buf[i], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        strings_sent++;
    endtask

    task automatic send_text(input string text);
        literal_buf.delete();
        for (int i = 0; i < text.len(); i++) literal_buf.push_back(text[i]);
        send_literal();
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
    endtask

    function automatic logic [7:0] random_digit();
        return dlv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_sign();
        return $urandom_range(0, 1) ? dlv_pkg::CHAR_PLUS : dlv_pkg::CHAR_MINUS;
    endfunction

    function automatic logic [7:0] random_special();
        case ($urandom_range(0, 6))
            0:       return dlv_pkg::CHAR_PLUS;
            1:       return dlv_pkg::CHAR_MINUS;
            2:       return dlv_pkg::CHAR_DOT;
            3:       return dlv_pkg::CHAR_EXP;
            4:       return dlv_pkg::CHAR_SPACE;
            5:       return random_digit();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed literals with random content, some damaged
    function automatic void build_random_literal();
        int unsigned n;
        int unsigned pos;
        literal_buf.delete();
        n = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
        repeat (n) literal_buf.push_back(dlv_pkg::CHAR_SPACE);
        if ($urandom_range(0, 99) < 30)
            literal_buf.push_back(random_sign());
        n = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 4);
        repeat (n) literal_buf.push_back(random_digit());
        if ($urandom_range(0, 99) < 35) begin
            literal_buf.push_back(dlv_pkg::CHAR_DOT);
            repeat ($urandom_range(0, 3)) literal_buf.push_back(random_digit());
        end
        if ($urandom_range(0, 99) < 30) begin
            literal_buf.push_back(dlv_pkg::CHAR_EXP);
            if ($urandom_range(0, 99) < 40)
                literal_buf.push_back(random_sign());
            n = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 3);
            repeat (n) literal_buf.push_back(random_digit());
        end
        n = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
        repeat (n) literal_buf.push_back(dlv_pkg::CHAR_SPACE);
        if ($urandom_range(0, 99) < 25) begin
            pos = $urandom_range(0, literal_buf.size());
            case ($urandom_range(0, 3))
                0: literal_buf.insert(pos, random_special());
                1: literal_buf.insert(pos, 8'($urandom_range(0, 255)));
                2: if (pos < literal_buf.size()) literal_buf[pos] = random_special();
                default: if (pos < literal_buf.size()) literal_buf.delete(pos);
            endcase
        end
    endfunction

    task automatic test_directed_literals();
        send_text(" 0");
        send_text("+.5");
        send_text("9e-1 ");
        send_text("");
        send_text("1 2");
        send_text("e1");
        literal_buf.delete();
        literal_buf.push_back(8'h00);
        send_literal();
        literal_buf.delete();
        literal_buf.push_back(8'hff);
        send_literal();
        wait_results();
    endtask

    task automatic test_random_literals(input int unsigned items);
        int unsigned stop_at;
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            build_random_literal();
            send_literal();
        end
    endtask

    task automatic test_full_rate(input int unsigned items);
        no_gaps = 1'b1;
        test_random_literals(items);
        no_gaps = 1'b0;
    endtask

    // result side held off while bytes keep coming, so the input must stall
    task automatic test_backpressure();
        no_gaps       = 1'b1;
        sink_hold_req = 1'b1;
        repeat (30) begin
            literal_buf.delete();
            literal_buf.push_back(random_digit());
            send_literal();
        end
        no_gaps = 1'b0;
        wait_results();
    endtask

    task automatic test_pause_for_results(input int unsigned items);
        int unsigned stop_at;
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            repeat ($urandom_range(1, 6)) begin
                build_random_literal();
                send_literal();
            end
            wait_results();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_literals();
        test_random_literals(850);
        test_full_rate(250);
        test_backpressure();
        test_pause_for_results(300);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d strings in %0d byte transfers: %0d judged valid, %0d invalid",
                 strings_sent, sent_items, valid_seen, invalid_seen);
        $display("input held back on %0d cycles, %0d mismatches", input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("decimal_literal_validator_core verification clean");
        end else begin
            $display("decimal_literal_validator_core verification failed");
        end
        $finish;
    end

endmodule
